@@ hdl/v3au_pkg.sv @@
package v3au_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int EXT_W         = PROD_W + 2;
  localparam int SQRT_STEPS    = DATA_W;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_SUB    = 3'd1;
  localparam logic [2:0] OP_SUBS   = 3'd2;
  localparam logic [2:0] OP_DOT    = 3'd3;
  localparam logic [2:0] OP_SCALE  = 3'd4;
  localparam logic [2:0] OP_CROSS  = 3'd5;
  localparam logic [2:0] OP_LEN    = 3'd6;
  localparam logic [2:0] OP_NORM   = 3'd7;

  localparam logic signed [EXT_W-1:0] SAT_MAX = EXT_W'((65'sd1 <<< (DATA_W - 1)) - 65'sd1);
  localparam logic signed [EXT_W-1:0] SAT_MIN = -SAT_MAX - EXT_W'(1);

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              ov;
  } sat_t;

  // per-item payload carried down the long pipe
  typedef struct packed {
    logic [2:0]              op;
    logic [2:0][DATA_W-1:0]  vec;
    logic [DATA_W-1:0]       sc;
    logic                    ov;
    logic [2:0]              neg;
    logic [2:0][DATA_W-1:0]  mag;
  } carry_t;

  // one finished result word
  typedef struct packed {
    logic [DATA_W-1:0] rx;
    logic [DATA_W-1:0] ry;
    logic [DATA_W-1:0] rz;
    logic [DATA_W-1:0] sc;
    logic              ov;
    logic              zl;
  } res_t;

  function automatic sat_t sat32(input logic signed [EXT_W-1:0] v);
    sat_t s;
    if (v > SAT_MAX) begin
      s.val = SAT_MAX[DATA_W-1:0];
      s.ov  = 1'b1;
    end else if (v < SAT_MIN) begin
      s.val = SAT_MIN[DATA_W-1:0];
      s.ov  = 1'b1;
    end else begin
      s.val = v[DATA_W-1:0];
      s.ov  = 1'b0;
    end
    return s;
  endfunction

endpackage

@@ hdl/vector3_arithmetic_unit.sv @@
// Words are Q16.16 at the default FRAC_BITS. Throughput: one word per cycle
// while the skid slot is empty; every opcode runs the same fixed-length pipe.
// Depth is set by the 32 restoring square-root steps plus FRAC_BITS+1 divide steps.
// A one-word output skid register catches a refused finished word; while it is
// full the pipe stalls. Reset (rst_n low, synchronous) clears all valid bits.
module vector3_arithmetic_unit #(
  parameter int FRAC_BITS = v3au_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       in_req_type,
  input  logic signed [v3au_pkg::DATA_W-1:0] in_ax,
  input  logic signed [v3au_pkg::DATA_W-1:0] in_ay,
  input  logic signed [v3au_pkg::DATA_W-1:0] in_az,
  input  logic signed [v3au_pkg::DATA_W-1:0] in_bx,
  input  logic signed [v3au_pkg::DATA_W-1:0] in_by,
  input  logic signed [v3au_pkg::DATA_W-1:0] in_bz,
  input  logic signed [v3au_pkg::DATA_W-1:0] in_scalar_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [v3au_pkg::DATA_W-1:0] out_rx,
  output logic signed [v3au_pkg::DATA_W-1:0] out_ry,
  output logic signed [v3au_pkg::DATA_W-1:0] out_rz,
  output logic signed [v3au_pkg::DATA_W-1:0] out_scalar_out,
  output logic                             out_overflow,
  output logic                             out_zero_length
);

  localparam int DW   = v3au_pkg::DATA_W;
  localparam int PW   = v3au_pkg::PROD_W;
  localparam int EW   = v3au_pkg::EXT_W;
  localparam int NSQ  = v3au_pkg::SQRT_STEPS;
  localparam int NDV  = FRAC_BITS + 1;        // quotient bits of normalize
  localparam int RW   = DW + FRAC_BITS + 1;   // divide remainder width
  localparam int LAST = NSQ + NDV;

  // whole pipe moves while the skid slot is empty
  logic en;
  logic skid_v_r;
  assign en       = ~skid_v_r;
  assign in_ready = en;

  // ---------------- stage 1: operand select, multiplies, linear ops
  logic signed [DW-1:0] av [0:2];
  logic signed [DW-1:0] bv [0:2];
  logic signed [DW-1:0] ma [0:5];
  logic signed [DW-1:0] mb [0:5];
  logic signed [DW:0]   lin_nxt [0:2];

  logic                 v1_r;
  logic [2:0]           op1_r;
  logic signed [PW-1:0] p1_r [0:5];
  logic signed [DW:0]   lin1_r [0:2];
  logic [2:0]           neg1_r;
  logic [DW-1:0]        mag1_r [0:2];

  assign av[0] = in_ax;
  assign av[1] = in_ay;
  assign av[2] = in_az;
  assign bv[0] = in_bx;
  assign bv[1] = in_by;
  assign bv[2] = in_bz;

  always_comb begin
    // cross-product minus terms are always the same pairs
    ma[3] = in_az; mb[3] = in_by;
    ma[4] = in_ax; mb[4] = in_bz;
    ma[5] = in_ay; mb[5] = in_bx;
    case (in_req_type)
      v3au_pkg::OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = av[i]; mb[i] = bv[i];
        end
      end
      v3au_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = in_scalar_in; mb[i] = av[i];
        end
      end
      v3au_pkg::OP_CROSS: begin
        ma[0] = in_ay; mb[0] = in_bz;
        ma[1] = in_az; mb[1] = in_bx;
        ma[2] = in_ax; mb[2] = in_by;
      end
      default: begin
        // squares for length and normalize
        for (int i = 0; i < 3; i++) begin
          ma[i] = av[i]; mb[i] = av[i];
        end
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      case (in_req_type)
        v3au_pkg::OP_ADD:  lin_nxt[i] = (DW+1)'(av[i]) + (DW+1)'(bv[i]);
        v3au_pkg::OP_SUB:  lin_nxt[i] = (DW+1)'(av[i]) - (DW+1)'(bv[i]);
        default:           lin_nxt[i] = (DW+1)'(av[i]) - (DW+1)'(in_scalar_in);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= in_req_type;
      for (int i = 0; i < 6; i++) begin
        p1_r[i] <= PW'(ma[i]) * PW'(mb[i]);
      end
      for (int i = 0; i < 3; i++) begin
        lin1_r[i] <= lin_nxt[i];
        neg1_r[i] <= av[i][DW-1];
        mag1_r[i] <= av[i][DW-1] ? DW'(-av[i]) : DW'(av[i]);
      end
    end
  end

  // ---------------- stage 2: exact sums, floor shift, sum of squares
  logic signed [EW-1:0] e_nxt [0:2];
  logic signed [EW-1:0] sum_dot;
  logic signed [EW-1:0] diff [0:2];
  logic [PW-1:0]        sq_nxt;

  logic                 v2_r;
  logic [2:0]           op2_r;
  logic signed [EW-1:0] e2_r [0:2];
  logic [PW-1:0]        sq2_r;
  logic [2:0]           neg2_r;
  logic [DW-1:0]        mag2_r [0:2];

  always_comb begin
    sum_dot = EW'(p1_r[0]) + EW'(p1_r[1]) + EW'(p1_r[2]);
    sq_nxt  = PW'(p1_r[0]) + PW'(p1_r[1]) + PW'(p1_r[2]);
    for (int i = 0; i < 3; i++) begin
      diff[i] = EW'(p1_r[i]) - EW'(p1_r[i+3]);
    end
    for (int i = 0; i < 3; i++) begin
      case (op1_r)
        v3au_pkg::OP_DOT: begin
          // keep the shift arithmetic: dot sum floors toward minus infinity
          e_nxt[i] = '0;
          if (i == 0) begin
            e_nxt[i] = sum_dot >>> FRAC_BITS;
          end
        end
        v3au_pkg::OP_SCALE: e_nxt[i] = EW'(p1_r[i]) >>> FRAC_BITS;
        v3au_pkg::OP_CROSS: e_nxt[i] = diff[i] >>> FRAC_BITS;
        default:            e_nxt[i] = EW'(lin1_r[i]);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2_r  <= op1_r;
      sq2_r  <= sq_nxt;
      neg2_r <= neg1_r;
      for (int i = 0; i < 3; i++) begin
        e2_r[i]   <= e_nxt[i];
        mag2_r[i] <= mag1_r[i];
      end
    end
  end

  // ---------------- stage 3: saturate, seed square root
  logic              v_r   [0:LAST];
  v3au_pkg::carry_t  c_r   [0:LAST];
  logic [PW-1:0]     x_r   [0:NSQ-1];
  logic [PW-1:0]     res_r [0:NSQ];
  v3au_pkg::carry_t  c0_nxt;
  v3au_pkg::sat_t    s3 [0:2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s3[i] = v3au_pkg::sat32(e2_r[i]);
    end
    c0_nxt.op  = op2_r;
    c0_nxt.neg = neg2_r;
    for (int i = 0; i < 3; i++) begin
      c0_nxt.mag[i] = mag2_r[i];
      c0_nxt.vec[i] = '0;
    end
    c0_nxt.sc = '0;
    c0_nxt.ov = 1'b0;
    case (op2_r)
      v3au_pkg::OP_DOT: begin
        c0_nxt.sc = s3[0].val;
        c0_nxt.ov = s3[0].ov;
      end
      v3au_pkg::OP_LEN, v3au_pkg::OP_NORM: begin
        c0_nxt.ov = 1'b0;
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          c0_nxt.vec[i] = s3[i].val;
        end
        c0_nxt.ov = s3[0].ov | s3[1].ov | s3[2].ov;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r[0]   <= c0_nxt;
      x_r[0]   <= sq2_r;
      res_r[0] <= '0;
    end
  end

  // ---------------- square root, one result bit per stage
  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    localparam logic [PW-1:0] BIT = PW'(1) << (PW - 2 - 2 * k);
    logic [PW-1:0] trial;
    logic          take;

    assign trial = res_r[k] + BIT;
    assign take  = (x_r[k] >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c_r[k+1]   <= c_r[k];
        res_r[k+1] <= take ? ((res_r[k] >> 1) + BIT) : (res_r[k] >> 1);
      end
    end

    if (k < NSQ - 1) begin : g_x
      always_ff @(posedge clk) begin
        if (en) begin
          x_r[k+1] <= take ? (x_r[k] - trial) : x_r[k];
        end
      end
    end
  end

  // ---------------- normalize divide, one quotient bit per stage, three lanes
  logic [2:0][RW-1:0]      rem_r [1:NDV-1];
  logic [2:0][FRAC_BITS:0] q_r   [1:NDV];
  logic [DW-1:0]           len_r [1:NDV];

  for (genvar j = 0; j < NDV; j++) begin : g_div
    localparam int KB = FRAC_BITS - j;
    logic [2:0][RW-1:0]      rem_in;
    logic [2:0][FRAC_BITS:0] q_in;
    logic [DW-1:0]           len_in;
    logic [RW-1:0]           dsh;
    logic [2:0]              take;
    logic [2:0][RW-1:0]      rem_nxt;
    logic [2:0][FRAC_BITS:0] q_nxt;

    if (j == 0) begin : g_seed
      always_comb begin
        len_in = res_r[NSQ][DW-1:0];
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = {1'b0, c_r[NSQ].mag[i], {FRAC_BITS{1'b0}}};
          q_in[i]   = '0;
        end
      end
    end else begin : g_mid
      always_comb begin
        len_in = len_r[j];
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = rem_r[j][i];
          q_in[i]   = q_r[j][i];
        end
      end
    end

    always_comb begin
      dsh = RW'(len_in) << KB;
      for (int i = 0; i < 3; i++) begin
        take[i]    = (rem_in[i] >= dsh);
        rem_nxt[i] = take[i] ? (rem_in[i] - dsh) : rem_in[i];
        q_nxt[i]   = q_in[i] | ((FRAC_BITS+1)'(take[i]) << KB);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[NSQ+j+1] <= 1'b0;
      end else if (en) begin
        v_r[NSQ+j+1] <= v_r[NSQ+j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c_r[NSQ+j+1] <= c_r[NSQ+j];
        len_r[j+1]   <= len_in;
        q_r[j+1]     <= q_nxt;
      end
    end

    if (j < NDV - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j+1] <= rem_nxt;
        end
      end
    end
  end

  // ---------------- final stage: pick result per opcode
  v3au_pkg::res_t fin_nxt;
  v3au_pkg::res_t fin_r;
  logic           fin_v_r;
  logic [2:0]     fin_op_r;
  logic [DW-1:0]  nq [0:2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nq[i] = c_r[LAST].neg[i] ? -DW'(q_r[NDV][i]) : DW'(q_r[NDV][i]);
    end
    fin_nxt.rx = c_r[LAST].vec[0];
    fin_nxt.ry = c_r[LAST].vec[1];
    fin_nxt.rz = c_r[LAST].vec[2];
    fin_nxt.sc = c_r[LAST].sc;
    fin_nxt.ov = c_r[LAST].ov;
    fin_nxt.zl = 1'b0;
    case (c_r[LAST].op)
      v3au_pkg::OP_LEN: begin
        // length above the signed range clips to max
        fin_nxt.sc = len_r[NDV][DW-1] ? v3au_pkg::SAT_MAX[DW-1:0] : len_r[NDV];
        fin_nxt.ov = len_r[NDV][DW-1];
      end
      v3au_pkg::OP_NORM: begin
        if (len_r[NDV] == '0) begin
          fin_nxt.zl = 1'b1;
        end else begin
          fin_nxt.rx = nq[0];
          fin_nxt.ry = nq[1];
          fin_nxt.rz = nq[2];
        end
      end
      default: begin
        fin_nxt.zl = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (en) begin
      fin_v_r <= v_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r    <= fin_nxt;
      fin_op_r <= c_r[LAST].op;
    end
  end

  // ---------------- output skid slot
  v3au_pkg::res_t skid_r;
  v3au_pkg::res_t out_w;
  logic           skid_v_nxt;

  always_comb begin
    if (skid_v_r) begin
      skid_v_nxt = ~out_ready;
    end else begin
      skid_v_nxt = fin_v_r & ~out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else begin
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      skid_r <= fin_r;
    end
  end

  assign out_w           = skid_v_r ? skid_r : fin_r;
  assign out_valid       = skid_v_r | fin_v_r;
  assign out_rx          = out_w.rx;
  assign out_ry          = out_w.ry;
  assign out_rz          = out_w.rz;
  assign out_scalar_out  = out_w.sc;
  assign out_overflow    = out_w.ov;
  assign out_zero_length = out_w.zl;

  // zero-vector normalize gives an all-zero word with no overflow
  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_length |->
      (out_rx == '0 && out_ry == '0 && out_rz == '0 && out_scalar_out == '0 && !out_overflow))
    else $error("zero_length word not clean");

  // skid fills only when a finished word was refused
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(fin_v_r && !out_ready))
    else $error("skid filled without a stall");

  // normalize quotient is bounded by one and never clips
  a_norm_ov: assert property (@(posedge clk) disable iff (!rst_n)
    fin_v_r && fin_op_r == v3au_pkg::OP_NORM |-> !fin_r.ov && fin_r.sc == '0)
    else $error("normalize flagged overflow");

  // scalar-result ops leave the vector zero
  a_scalar_vec: assert property (@(posedge clk) disable iff (!rst_n)
    fin_v_r && (fin_op_r == v3au_pkg::OP_DOT || fin_op_r == v3au_pkg::OP_LEN) |->
      (fin_r.rx == '0 && fin_r.ry == '0 && fin_r.rz == '0 && !fin_r.zl))
    else $error("scalar op produced a vector");

endmodule

@@ bench/tb_vector3_arithmetic_unit.sv @@
module tb_vector3_arithmetic_unit;

  localparam int FB       = v3au_pkg::FRAC_BITS_DEF;
  localparam int LAT      = 37 + FB;     // pipe depth in cycles
  localparam int N_RAND   = 500;
  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;
  localparam logic signed [31:0] ONE   = 32'sh00010000;

  typedef struct {
    logic [2:0]         op;
    logic signed [31:0] a [3];
    logic signed [31:0] b [3];
    logic signed [31:0] s;
  } vec_req_t;

  typedef struct {
    logic signed [31:0] rx, ry, rz, sc;
    logic               ov, zl;
  } vec_res_t;

  // directed row: request plus an optional hand-typed answer
  typedef struct {
    vec_req_t req;
    bit       typed;
    vec_res_t res;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_req_type = '0;
  logic signed [31:0] in_ax = '0, in_ay = '0, in_az = '0;
  logic signed [31:0] in_bx = '0, in_by = '0, in_bz = '0, in_scalar_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_rx, out_ry, out_rz, out_scalar_out;
  logic out_overflow, out_zero_length;

  vec_res_t pending_res [$];
  int  n_err = 0;
  int  hold_req = 0;      // sender asks the receiver for a long hold-off
  int  hold_left = 0;
  bit  no_idle = 1'b0;    // stretch with both sides busy every cycle
  bit  started = 1'b0;

  always #1 clk = ~clk;

  vector3_arithmetic_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_ax(in_ax), .in_ay(in_ay), .in_az(in_az),
    .in_bx(in_bx), .in_by(in_by), .in_bz(in_bz), .in_scalar_in(in_scalar_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_rx(out_rx), .out_ry(out_ry), .out_rz(out_rz),
    .out_scalar_out(out_scalar_out), .out_overflow(out_overflow),
    .out_zero_length(out_zero_length)
  );

  // clamp a wide value into a Q16.16 word, noting overflow
  function automatic logic signed [31:0] clamp_q(input logic signed [127:0] v,
                                                 inout logic ov);
    if (v > 128'sh7fffffff) begin
      ov = 1'b1;
      return Q_MAX;
    end
    if (v < -128'sh80000000) begin
      ov = 1'b1;
      return Q_MIN;
    end
    return v[31:0];
  endfunction

  // floor square root, restoring digit-by-digit
  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] root, bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic vec_res_t vec_alu(input vec_req_t q);
    vec_res_t r;
    logic signed [127:0] a [3], b [3], s, acc;
    logic signed [31:0] rv [3];
    logic [63:0] sq, len;
    logic [63:0] mag, quo;
    r = '{default: '0};
    rv = '{default: '0};
    for (int i = 0; i < 3; i++) begin
      a[i] = q.a[i];
      b[i] = q.b[i];
    end
    s = q.s;
    case (q.op)
      v3au_pkg::OP_ADD:
        for (int i = 0; i < 3; i++) rv[i] = clamp_q(a[i] + b[i], r.ov);
      v3au_pkg::OP_SUB:
        for (int i = 0; i < 3; i++) rv[i] = clamp_q(a[i] - b[i], r.ov);
      v3au_pkg::OP_SUBS:
        for (int i = 0; i < 3; i++) rv[i] = clamp_q(a[i] - s, r.ov);
      v3au_pkg::OP_DOT: begin
        acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        r.sc = clamp_q(acc >>> FB, r.ov);
      end
      v3au_pkg::OP_SCALE:
        for (int i = 0; i < 3; i++) rv[i] = clamp_q((s * a[i]) >>> FB, r.ov);
      v3au_pkg::OP_CROSS: begin
        rv[0] = clamp_q((a[1] * b[2] - a[2] * b[1]) >>> FB, r.ov);
        rv[1] = clamp_q((a[2] * b[0] - a[0] * b[2]) >>> FB, r.ov);
        rv[2] = clamp_q((a[0] * b[1] - a[1] * b[0]) >>> FB, r.ov);
      end
      default: begin
        acc = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        sq  = acc[63:0];
        len = floor_sqrt(sq);
        if (q.op == v3au_pkg::OP_LEN) begin
          r.sc = clamp_q($signed({64'd0, len}), r.ov);
        end else if (len == 0) begin
          r.zl = 1'b1;
        end else begin
          // normalize divides by the unsaturated length, truncating
          for (int i = 0; i < 3; i++) begin
            mag = (a[i] < 0) ? 64'(-a[i]) : 64'(a[i]);
            quo = (mag << FB) / len;
            acc = (a[i] < 0) ? -$signed({64'd0, quo}) : $signed({64'd0, quo});
            rv[i] = clamp_q(acc, r.ov);
          end
        end
      end
    endcase
    r.rx = rv[0];
    r.ry = rv[1];
    r.rz = rv[2];
    return r;
  endfunction

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(7))
      0: return $urandom_range(1) ? Q_MAX : Q_MIN;
      1, 2: return $signed($urandom_range(20 * ONE)) - 10 * ONE;
      3: return $signed($urandom_range(3)) - 1;
      default: return $urandom;
    endcase
  endfunction

  function automatic vec_req_t rand_req();
    vec_req_t q;
    q.op = 3'($urandom_range(7));
    for (int i = 0; i < 3; i++) begin
      q.a[i] = rand_q();
      q.b[i] = rand_q();
    end
    q.s = rand_q();
    // zero vector now and then for the normalize/length corner
    if ($urandom_range(15) == 0) q.a = '{default: '0};
    return q;
  endfunction

  function automatic vec_req_t mk(input logic [2:0] op,
      input logic signed [31:0] ax, ay, az, bx, by, bz, s);
    vec_req_t q;
    q.op = op;
    q.a = '{ax, ay, az};
    q.b = '{bx, by, bz};
    q.s = s;
    return q;
  endfunction

  function automatic vec_res_t mkr(input logic signed [31:0] rx, ry, rz, sc,
                                   input logic ov, zl);
    vec_res_t r;
    r.rx = rx; r.ry = ry; r.rz = rz; r.sc = sc; r.ov = ov; r.zl = zl;
    return r;
  endfunction

  // present one word and wait for its handshake; a gap comes first at random
  task automatic send_word(input vec_req_t q, input vec_res_t exp_r);
    while (!no_idle && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= q.op;
    in_ax <= q.a[0]; in_ay <= q.a[1]; in_az <= q.a[2];
    in_bx <= q.b[0]; in_by <= q.b[1]; in_bz <= q.b[2];
    in_scalar_in <= q.s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_res.push_back(exp_r);
  endtask

  // receiver: random stalls, a counted long hold-off on request
  always @(posedge clk) begin
    if (!started) begin
      out_ready <= 1'b0;
    end else if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 27);
    end
  end

  // result checker against the oldest expectation
  always @(posedge clk) begin
    vec_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_res.size() == 0) begin
        $error("result word with nothing expected");
        n_err++;
      end else begin
        e = pending_res.pop_front();
        if (out_rx !== e.rx) begin
          $error("rx: expected %h, got %h", e.rx, out_rx); n_err++;
        end
        if (out_ry !== e.ry) begin
          $error("ry: expected %h, got %h", e.ry, out_ry); n_err++;
        end
        if (out_rz !== e.rz) begin
          $error("rz: expected %h, got %h", e.rz, out_rz); n_err++;
        end
        if (out_scalar_out !== e.sc) begin
          $error("scalar_out: expected %h, got %h", e.sc, out_scalar_out); n_err++;
        end
        if (out_overflow !== e.ov) begin
          $error("overflow: expected %b, got %b", e.ov, out_overflow); n_err++;
        end
        if (out_zero_length !== e.zl) begin
          $error("zero_length: expected %b, got %b", e.zl, out_zero_length); n_err++;
        end
      end
    end
  end

  initial begin
    #400000;
    $display("vector3_arithmetic_unit test failed");
    $finish;
  end

  initial begin
    vec_row_t rows [$];
    vec_row_t row;
    vec_req_t q;
    int wait_cnt;

    // directed table; typed answers only where obvious
    row.typed = 1'b1;
    row.req = mk(v3au_pkg::OP_ADD, Q_MAX, 0, 0, 1, 0, 0, 0);
    row.res = mkr(Q_MAX, 0, 0, 0, 1'b1, 1'b0);                    rows.push_back(row);
    row.req = mk(v3au_pkg::OP_SUB, Q_MIN, 0, 0, 1, 0, 0, 0);
    row.res = mkr(Q_MIN, 0, 0, 0, 1'b1, 1'b0);                    rows.push_back(row);
    row.req = mk(v3au_pkg::OP_NORM, 0, 0, 0, Q_MAX, Q_MIN, 1, Q_MAX);
    row.res = mkr(0, 0, 0, 0, 1'b0, 1'b1);                        rows.push_back(row);
    row.req = mk(v3au_pkg::OP_LEN, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0);
    row.res = mkr(0, 0, 0, 5 * ONE, 1'b0, 1'b0);                  rows.push_back(row);
    row.req = mk(v3au_pkg::OP_ADD, ONE, 2 * ONE, 3 * ONE, ONE, ONE, 7 * ONE, 0);
    row.res = mkr(2 * ONE, 3 * ONE, 10 * ONE, 0, 1'b0, 1'b0);     rows.push_back(row);
    row.typed = 1'b0;
    row.req = mk(v3au_pkg::OP_SUBS, Q_MIN, Q_MAX, 0, 0, 0, 0, Q_MAX);
    rows.push_back(row);
    row.req = mk(v3au_pkg::OP_SUBS, Q_MAX, Q_MIN, -1, 0, 0, 0, Q_MIN);
    rows.push_back(row);
    row.req = mk(v3au_pkg::OP_DOT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0);
    rows.push_back(row);
    row.req = mk(v3au_pkg::OP_DOT, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0);
    rows.push_back(row);
    row.req = mk(v3au_pkg::OP_DOT, -1, 1, -1, 1, 1, 1, 0);
    rows.push_back(row);
    row.req = mk(v3au_pkg::OP_SCALE, Q_MIN, Q_MAX, -ONE, 0, 0, 0, Q_MIN);
    rows.push_back(row);
    row.req = mk(v3au_pkg::OP_SCALE, -3, 5, ONE, 0, 0, 0, -1);
    rows.push_back(row);
    row.req = mk(v3au_pkg::OP_CROSS, ONE, 0, 0, 0, ONE, 0, 0);
    rows.push_back(row);
    row.req = mk(v3au_pkg::OP_CROSS, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 0);
    rows.push_back(row);
    row.req = mk(v3au_pkg::OP_LEN, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0);
    rows.push_back(row);
    row.req = mk(v3au_pkg::OP_LEN, 1, 0, 0, 0, 0, 0, 0);
    rows.push_back(row);
    // huge length: normalize still uses the unsaturated length
    row.req = mk(v3au_pkg::OP_NORM, Q_MIN, Q_MAX, Q_MIN, 0, 0, 0, 0);
    rows.push_back(row);
    row.req = mk(v3au_pkg::OP_NORM, 1, 0, 0, 0, 0, 0, 0);
    rows.push_back(row);
    row.req = mk(v3au_pkg::OP_NORM, -3 * ONE, 4 * ONE, 0, 0, 0, 0, 0);
    rows.push_back(row);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    started = 1'b1;

    foreach (rows[i])
      send_word(rows[i].req, rows[i].typed ? rows[i].res : vec_alu(rows[i].req));

    for (int n = 0; n < N_RAND; n++) begin
      if (n == 100) hold_req = 3 * LAT;   // long hold: fill the pipe, stall input
      no_idle = (n >= 200 && n < 300);
      if (n == 350) begin
        // sender pause until every word is back
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_res.size() != 0) @(posedge clk);
      end
      q = rand_req();
      send_word(q, vec_alu(q));
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    while (pending_res.size() != 0) @(posedge clk);
    wait_cnt = 0;
    while (wait_cnt < 2 * LAT) begin
      @(posedge clk);
      wait_cnt++;
    end

    if (n_err == 0 && pending_res.size() == 0) begin
      $display("vector3_arithmetic_unit test passed");
    end else begin
      $display("vector3_arithmetic_unit test failed");
    end
    $finish;
  end

endmodule
